/* hw/rtl/wmmf_pkg.sv */
`default_nettype none
package wmmf_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 11'd512;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 13'd512;

  localparam int WIN_N       = 9;
  localparam int PIX_W       = 24;
  localparam int SUM_W       = 12;
  localparam int RECIP_W     = 13;
  // floor(s/9) == (s*7282) >> 16 for every window sum s <= 9*255
  localparam logic [RECIP_W-1:0] RECIP9 = 13'd7282;
  localparam int RECIP_SHIFT = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    MODE_MEAN   = 1'b0,
    MODE_MEDIAN = 1'b1
  } mode_t;

  typedef logic [7:0] chan_t;

  typedef struct packed {
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;
    logic  flush;
  } pix_in_t;

  typedef struct packed {
    chan_t red_out;
    chan_t green_out;
    chan_t blue_out;
    logic  frame_end;
  } pix_out_t;

  typedef struct packed {
    logic              emit;
    logic              last;
    logic [WIN_N-1:0]  mask;
  } win_ctrl_t;

endpackage
`default_nettype wire

/* hw/rtl/wmmf_ram.sv */
`default_nettype none
module wmmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/wmmf_pos.sv */
`default_nettype none
module wmmf_pos #(
  parameter int MAX_WIDTH  = wmmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = wmmf_pkg::MAX_HEIGHT_DEF,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               acc,
  input  wire logic               restart,
  input  wire logic [WW-1:0]      w_eff,
  input  wire logic [HW-1:0]      h_eff,
  output logic      [CW-1:0]      addr,
  output wmmf_pkg::win_ctrl_t     ctrl
);

  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int AW = WW + HW;
  localparam int NW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  logic [WW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;

  logic          col_nz;
  logic [RW-1:0] cr;
  logic [WW-1:0] cc;
  logic [2:0]    rok, cok;
  logic [AW-1:0] area;

  assign addr   = col_r[CW-1:0];
  assign col_nz = col_r != '0;
  // window centre lags one row and one pixel behind the input
  assign cr     = col_nz ? row_r - RW'(1) : row_r - RW'(2);
  assign cc     = col_nz ? col_r - WW'(1) : w_eff - WW'(1);
  assign rok[0] = cr != '0;
  assign rok[1] = 1'b1;
  assign rok[2] = ((RW+1)'(cr) + (RW+1)'(1)) < (RW+1)'(h_eff);
  assign cok[0] = cc != '0;
  assign cok[1] = 1'b1;
  assign cok[2] = ((WW+1)'(cc) + (WW+1)'(1)) < (WW+1)'(w_eff);
  assign area   = AW'(w_eff) * AW'(h_eff);

  always_comb begin
    ctrl.emit = (row_r >= RW'(2)) || (row_r == RW'(1) && col_nz);
    ctrl.last = (AW'(cnt_r) + AW'(1)) == area;
    for (int k = 0; k < wmmf_pkg::WIN_N; k++) begin
      ctrl.mask[k] = rok[k / 3] & cok[k % 3];
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    cnt_nxt = cnt_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
      cnt_nxt = '0;
    end else if (acc) begin
      if (ctrl.emit && ctrl.last) begin
        col_nxt = '0;
        row_nxt = '0;
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + NW'(ctrl.emit);
        if ((WW+1)'(col_r) + (WW+1)'(1) >= (WW+1)'(w_eff)) begin
          col_nxt = '0;
          row_nxt = row_r + RW'(1);
        end else begin
          col_nxt = col_r + WW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      cnt_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    acc && ctrl.emit && ctrl.last |=> col_r == '0 && row_r == '0 && cnt_r == '0)
    else $error("position not cleared after frame end");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !ctrl.emit && !restart |=> cnt_r == $past(cnt_r))
    else $error("output count moved without an output");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !restart |=> (WW+1)'(col_r) < (WW+1)'(w_eff) || col_r == '0)
    else $error("column ran past image width");

endmodule
`default_nettype wire

/* hw/rtl/wmmf_win.sv */
`default_nettype none
module wmmf_win #(
  parameter int MAX_WIDTH = wmmf_pkg::MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   acc,
  input  wire logic [CW-1:0]                          addr,
  input  wire logic [wmmf_pkg::PIX_W-1:0]             pix,
  input  wmmf_pkg::win_ctrl_t                         ctrl_in,
  input  wire logic                                   en_w,
  input  wire logic                                   clear,
  output logic                                        s1_valid,
  output logic                                        w_valid,
  output wmmf_pkg::win_ctrl_t                         w_ctrl,
  output logic [wmmf_pkg::WIN_N-1:0][wmmf_pkg::PIX_W-1:0] win
);

  localparam int PW = wmmf_pkg::PIX_W;

  logic                 s1_valid_r;
  logic [CW-1:0]        s1_addr_r;
  logic [PW-1:0]        s1_pix_r;
  wmmf_pkg::win_ctrl_t  s1_ctrl_r;
  logic                 fwd_r;
  logic [PW-1:0]        fwd_up_r, fwd_mid_r;
  logic                 w_valid_r;
  wmmf_pkg::win_ctrl_t  w_ctrl_r;
  logic [wmmf_pkg::WIN_N-1:0][PW-1:0] win_r;

  logic          proc;
  logic [PW-1:0] up_q, mid_q, up_rd, mid_rd;

  assign proc   = s1_valid_r && en_w;
  // one-column image: the previous word writes the entry this one just read
  assign up_rd  = fwd_r ? fwd_up_r  : up_q;
  assign mid_rd = fwd_r ? fwd_mid_r : mid_q;

  wmmf_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper (
    .clk     (clk),
    .wr_en   (proc),
    .wr_addr (s1_addr_r),
    .wr_data (mid_rd),
    .rd_en   (acc),
    .rd_addr (addr),
    .rd_data (up_q)
  );

  wmmf_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_middle (
    .clk     (clk),
    .wr_en   (proc),
    .wr_addr (s1_addr_r),
    .wr_data (s1_pix_r),
    .rd_en   (acc),
    .rd_addr (addr),
    .rd_data (mid_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      w_valid_r  <= 1'b0;
      fwd_r      <= 1'b0;
      win_r      <= '0;
    end else begin
      if (acc) begin
        s1_valid_r <= 1'b1;
        s1_addr_r  <= addr;
        s1_pix_r   <= pix;
        s1_ctrl_r  <= ctrl_in;
        fwd_r      <= proc && (addr == s1_addr_r);
        fwd_up_r   <= mid_rd;
        fwd_mid_r  <= s1_pix_r;
      end else if (proc) begin
        s1_valid_r <= 1'b0;
      end
      if (en_w) begin
        w_valid_r <= proc && s1_ctrl_r.emit;
      end
      if (proc) begin
        w_ctrl_r <= s1_ctrl_r;
      end
      if (clear) begin
        win_r <= '0;
      end else if (proc) begin
        for (int row = 0; row < 3; row++) begin
          win_r[row*3]   <= win_r[row*3+1];
          win_r[row*3+1] <= win_r[row*3+2];
        end
        win_r[2] <= up_rd;
        win_r[5] <= mid_rd;
        win_r[8] <= s1_pix_r;
      end
    end
  end

  assign s1_valid = s1_valid_r;
  assign w_valid  = w_valid_r;
  assign w_ctrl   = w_ctrl_r;
  assign win      = win_r;

endmodule
`default_nettype wire

/* hw/rtl/wmmf_chan.sv */
`default_nettype none
module wmmf_chan (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic [wmmf_pkg::WIN_N-1:0][7:0]       vals,
  input  wire logic [wmmf_pkg::WIN_N-1:0]            mask,
  input  wire logic                                  en_a,
  input  wire logic                                  en_o,
  input  wire logic                                  a_vld,
  input  wmmf_pkg::mode_t                            mode,
  output logic [7:0]                                 res
);

  localparam int N  = wmmf_pkg::WIN_N;
  localparam int SW = wmmf_pkg::SUM_W;
  localparam int PW = SW + wmmf_pkg::RECIP_W;

  logic [N-1:0][N-1:0] lt_r;
  logic [N-1:0][7:0]   v_r;
  logic [N-1:0]        mask_r;
  logic [SW-1:0]       sum_r;
  logic [7:0]          res_r;

  logic [N-1:0][N-1:0] lt;
  logic [SW-1:0]       sum;
  logic [3:0]          n;
  logic [N-1:0][3:0]   rank;
  logic [N-1:0]        sel;
  logic [7:0]          med;
  logic [PW-1:0]       prod;

  // stage a: pairwise order with ties broken by position, and masked sum
  always_comb begin
    sum = '0;
    for (int i = 0; i < N; i++) begin
      if (mask[i]) begin
        sum = sum + SW'(vals[i]);
      end
      for (int j = 0; j < N; j++) begin
        lt[i][j] = mask[j] && ((vals[j] < vals[i]) || (vals[j] == vals[i] && j < i));
      end
    end
  end

  // stage b: the entry with exactly count/2 smaller neighbours is the median
  always_comb begin
    n   = '0;
    med = '0;
    for (int i = 0; i < N; i++) begin
      n = n + 4'(mask_r[i]);
    end
    for (int i = 0; i < N; i++) begin
      rank[i] = '0;
      for (int j = 0; j < N; j++) begin
        rank[i] = rank[i] + 4'(lt_r[i][j]);
      end
      sel[i] = mask_r[i] && (rank[i] == (n >> 1));
      med    = med | (v_r[i] & {8{sel[i]}});
    end
    prod = PW'(sum_r) * PW'(wmmf_pkg::RECIP9);
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      lt_r   <= lt;
      v_r    <= vals;
      mask_r <= mask;
      sum_r  <= sum;
    end
    if (en_o) begin
      res_r <= (mode == wmmf_pkg::MODE_MEDIAN) ? med : prod[wmmf_pkg::RECIP_SHIFT +: 8];
    end
  end

  assign res = res_r;

  a_med_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld && mask_r[4] |-> $onehot(sel))
    else $error("median select not unique");

endmodule
`default_nettype wire

/* hw/rtl/window_3x3_mean_median_filter.sv */
`default_nettype none
// 3x3 mean or median filter over an RGB raster stream, one pixel word per clock.
// A word is taken every cycle as long as results drain; output lags input by
// image_width+1 words plus the pipeline registers (line store read, window,
// compare, result). Two dual-port line stores of MAX_WIDTH entries hold the
// previous rows; their read-then-write per column sets the one-word-per-cycle
// rate. After the last pixel of a frame send image_width+1 flush words to drain
// it. Writing image_width or image_height restarts the frame; write
// configuration only while the block is idle.
module window_3x3_mean_median_filter #(
  parameter int MAX_WIDTH  = wmmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = wmmf_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wmmf_pkg::pix_in_t                     in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output wmmf_pkg::pix_out_t                    out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [wmmf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [wmmf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int N  = wmmf_pkg::WIN_N;

  wmmf_pkg::mode_t                     mode_r;
  logic [wmmf_pkg::WIDTH_REG_W-1:0]    width_r;
  logic [wmmf_pkg::HEIGHT_REG_W-1:0]   height_r;
  logic                                restart;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  logic en_o, en_a, en_w, acc;
  logic a_valid_r, a_last_r, out_valid_r, out_last_r;

  logic                 s1_valid, w_valid;
  wmmf_pkg::win_ctrl_t  ctrl, w_ctrl;
  logic [CW-1:0]        addr;
  logic [wmmf_pkg::PIX_W-1:0] pix;
  logic [N-1:0][wmmf_pkg::PIX_W-1:0] win;
  logic [N-1:0][7:0]    v_red, v_grn, v_blu;
  logic [7:0]           r_res, g_res, b_res;

  assign cfg_ready = 1'b1;

  always_comb begin
    restart = 1'b0;
    if (cfg_valid) begin
      case (wmmf_pkg::cfg_idx_t'(cfg_index))
        wmmf_pkg::CFG_WIDTH, wmmf_pkg::CFG_HEIGHT: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= wmmf_pkg::MODE_MEAN;
      width_r  <= wmmf_pkg::WIDTH_RST;
      height_r <= wmmf_pkg::HEIGHT_RST;
    end else if (cfg_valid) begin
      case (wmmf_pkg::cfg_idx_t'(cfg_index))
        wmmf_pkg::CFG_MODE:   mode_r   <= wmmf_pkg::mode_t'(cfg_data[0]);
        wmmf_pkg::CFG_WIDTH:  width_r  <= cfg_data[wmmf_pkg::WIDTH_REG_W-1:0];
        wmmf_pkg::CFG_HEIGHT: height_r <= cfg_data[wmmf_pkg::HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize clamps to the build limit
  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_r);
    end
  end

  // each stage moves when the one after it moves or is empty
  assign en_o     = !out_valid_r || !out_stall;
  assign en_a     = en_o || !a_valid_r;
  assign en_w     = en_a || !w_valid;
  assign in_stall = !(en_w || !s1_valid);
  assign acc      = in_valid && !in_stall;

  assign pix = in_data.flush ? '0 : {in_data.red_in, in_data.green_in, in_data.blue_in};

  wmmf_pos #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .restart (restart),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .addr    (addr),
    .ctrl    (ctrl)
  );

  wmmf_win #(.MAX_WIDTH(MAX_WIDTH)) u_win (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .addr     (addr),
    .pix      (pix),
    .ctrl_in  (ctrl),
    .en_w     (en_w),
    .clear    (restart),
    .s1_valid (s1_valid),
    .w_valid  (w_valid),
    .w_ctrl   (w_ctrl),
    .win      (win)
  );

  always_comb begin
    for (int k = 0; k < N; k++) begin
      v_red[k] = win[k][23:16];
      v_grn[k] = win[k][15:8];
      v_blu[k] = win[k][7:0];
    end
  end

  wmmf_chan u_red (
    .clk (clk), .rst_n (rst_n), .vals (v_red), .mask (w_ctrl.mask),
    .en_a (en_a), .en_o (en_o), .a_vld (a_valid_r), .mode (mode_r), .res (r_res)
  );

  wmmf_chan u_grn (
    .clk (clk), .rst_n (rst_n), .vals (v_grn), .mask (w_ctrl.mask),
    .en_a (en_a), .en_o (en_o), .a_vld (a_valid_r), .mode (mode_r), .res (g_res)
  );

  wmmf_chan u_blu (
    .clk (clk), .rst_n (rst_n), .vals (v_blu), .mask (w_ctrl.mask),
    .en_a (en_a), .en_o (en_o), .a_vld (a_valid_r), .mode (mode_r), .res (b_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_a) begin
        a_valid_r <= w_valid;
        a_last_r  <= w_ctrl.last;
      end
      if (en_o) begin
        out_valid_r <= a_valid_r;
        out_last_r  <= a_last_r;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data.red_out   = r_res;
  assign out_data.green_out = g_res;
  assign out_data.blue_out  = b_res;
  assign out_data.frame_end = out_last_r;

endmodule
`default_nettype wire

/* dv/tb_window_3x3_mean_median_filter.sv */
module tb_window_3x3_mean_median_filter;

  class pixel_scoreboard;
    logic [23:0] upper_row[wmmf_pkg::MAX_WIDTH_DEF];
    logic [23:0] middle_row[wmmf_pkg::MAX_WIDTH_DEF];
    logic [23:0] win[9];
    int col, row, out_n;
    wmmf_pkg::mode_t mode;
    int width_reg, height_reg;
    wmmf_pkg::pix_out_t pending[$];
    int errors, results;

    function new();
      foreach (upper_row[i]) begin
        upper_row[i] = '0;
        middle_row[i] = '0;
      end
      mode = wmmf_pkg::MODE_MEAN;
      width_reg = 512;
      height_reg = 512;
      errors = 0;
      results = 0;
      restart();
    endfunction

    function int clamp_dim(int v, int m);
      if (v < 1) return 1;
      if (v > m) return m;
      return v;
    endfunction

    function int eff_w();
      return clamp_dim(width_reg, wmmf_pkg::MAX_WIDTH_DEF);
    endfunction

    function int eff_h();
      return clamp_dim(height_reg, wmmf_pkg::MAX_HEIGHT_DEF);
    endfunction

    function void restart();
      col = 0;
      row = 0;
      out_n = 0;
      foreach (win[i]) win[i] = '0;
    endfunction

    function void write_reg(wmmf_pkg::cfg_idx_t idx, int v);
      case (idx)
        wmmf_pkg::CFG_MODE: begin
          mode = wmmf_pkg::mode_t'(v[0]);
        end
        wmmf_pkg::CFG_WIDTH: begin
          width_reg = v & 32'h7ff;
          restart();
        end
        wmmf_pkg::CFG_HEIGHT: begin
          height_reg = v & 32'h1fff;
          restart();
        end
        default: ;
      endcase
    endfunction

    // mean over 9 regardless of count, median at index n/2 of in-image taps
    function wmmf_pkg::chan_t filter_chan(bit inside_img[9], int sh);
      int vals[9];
      int n, sum, v, p;
      n = 0;
      sum = 0;
      for (int k = 0; k < 9; k++) begin
        if (inside_img[k]) begin
          v = (win[k] >> sh) & 8'hff;
          sum += v;
          p = n;
          while (p > 0 && vals[p-1] > v) begin
            vals[p] = vals[p-1];
            p--;
          end
          vals[p] = v;
          n++;
        end
      end
      if (mode == wmmf_pkg::MODE_MEAN) return wmmf_pkg::chan_t'(sum / 9);
      if (n == 0) return '0;
      return wmmf_pkg::chan_t'(vals[n/2]);
    endfunction

    function void note_word(wmmf_pkg::pix_in_t w_in);
      int w, h, c, r, cr, cc, rr, cl;
      logic [23:0] pix;
      bit inside_img[9];
      wmmf_pkg::pix_out_t e;
      w = eff_w();
      h = eff_h();
      c = col;
      r = row;
      pix = w_in.flush ? 24'h0 : {w_in.red_in, w_in.green_in, w_in.blue_in};
      for (int i = 0; i < 3; i++) begin
        win[i*3] = win[i*3+1];
        win[i*3+1] = win[i*3+2];
      end
      if (c < wmmf_pkg::MAX_WIDTH_DEF) begin
        win[2] = upper_row[c];
        win[5] = middle_row[c];
        upper_row[c] = middle_row[c];
        middle_row[c] = pix;
      end else begin
        win[2] = '0;
        win[5] = '0;
      end
      win[8] = pix;
      if (r >= 2 || (r == 1 && c >= 1)) begin
        if (c >= 1) begin
          cr = r - 1;
          cc = c - 1;
        end else begin
          cr = r - 2;
          cc = w - 1;
        end
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++) begin
            rr = cr + dr;
            cl = cc + dc;
            inside_img[(dr+1)*3 + dc+1] = rr >= 0 && rr < h && cl >= 0 && cl < w;
          end
        e.red_out = filter_chan(inside_img, 16);
        e.green_out = filter_chan(inside_img, 8);
        e.blue_out = filter_chan(inside_img, 0);
        e.frame_end = (out_n + 1) == w * h;
        pending.push_back(e);
        out_n++;
        if (e.frame_end) begin
          col = 0;
          row = 0;
          out_n = 0;
          return;
        end
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      col = c;
      row = r;
    endfunction

    function void check_word(wmmf_pkg::pix_out_t got);
      wmmf_pkg::pix_out_t e;
      results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.red_out !== e.red_out)
        $display("%0t: red expected %h actual %h", $time, e.red_out, got.red_out);
      if (got.green_out !== e.green_out)
        $display("%0t: green expected %h actual %h", $time, e.green_out, got.green_out);
      if (got.blue_out !== e.blue_out)
        $display("%0t: blue expected %h actual %h", $time, e.blue_out, got.blue_out);
      if (got.frame_end !== e.frame_end)
        $display("%0t: frame_end expected %b actual %b", $time, e.frame_end, got.frame_end);
      if (got !== e) errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  wmmf_pkg::pix_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  wmmf_pkg::pix_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [wmmf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [wmmf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pixel_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;
  int frames_done = 0;

  window_3x3_mean_median_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk)
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_word(out_data);

  task automatic send_word(wmmf_pkg::pix_in_t p);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    sb.note_word(p);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    // a flush word may still be in the pipe with nothing expected
    repeat (12) @(negedge clk);
  endtask

  // valid stays high so writes can follow back to back; caller drops it
  task automatic write_cfg(wmmf_pkg::cfg_idx_t idx, int v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[wmmf_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic set_phase(wmmf_pkg::mode_t m, int w, int h);
    wait_drain();
    write_cfg(wmmf_pkg::CFG_MODE, m);
    write_cfg(wmmf_pkg::CFG_WIDTH, w);
    write_cfg(wmmf_pkg::CFG_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  function automatic wmmf_pkg::chan_t pick_chan();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hff;
      default: return wmmf_pkg::chan_t'($urandom);
    endcase
  endfunction

  function automatic wmmf_pkg::pix_in_t pick_word(bit flush);
    wmmf_pkg::pix_in_t p;
    p.red_in = pick_chan();
    p.green_in = pick_chan();
    p.blue_in = pick_chan();
    p.flush = flush;
    return p;
  endfunction

  // full frame plus the drain words; drain words are sometimes real pixels
  task automatic run_frame(int flush_pct);
    int w, h;
    w = sb.eff_w();
    h = sb.eff_h();
    for (int i = 0; i < w * h; i++)
      send_word(pick_word($urandom_range(99) < flush_pct));
    for (int i = 0; i <= w; i++)
      send_word(pick_word($urandom_range(9) != 0));
    frames_done++;
  endtask

  // start of a frame only, cut short by the next size write
  task automatic run_partial(int n);
    for (int i = 0; i < n; i++)
      send_word(pick_word($urandom_range(9) == 0));
  endtask

  task automatic pick_idling(int n);
    case (n % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 58; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 58; end
      default: begin idle_pct = 25; stall_pct = 25; end
    endcase
  endtask

  initial begin
    int ph;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: 3x3 both modes, flush inside a frame, pixels during drain
    set_phase(wmmf_pkg::MODE_MEAN, 3, 3);
    run_frame(20);
    set_phase(wmmf_pkg::MODE_MEDIAN, 3, 3);
    run_frame(20);
    // size extremes, out-of-range values saturate
    set_phase(wmmf_pkg::MODE_MEDIAN, 0, 0);
    run_frame(0);
    set_phase(wmmf_pkg::MODE_MEAN, 2047, 1);
    run_partial(40);
    set_phase(wmmf_pkg::MODE_MEDIAN, 1024, 2);
    run_partial(60);
    set_phase(wmmf_pkg::MODE_MEAN, 1, 8191);
    run_partial(40);
    set_phase(wmmf_pkg::MODE_MEDIAN, 2, 4096);
    run_partial(60);
    wait_drain();

    ph = 0;
    while (words_sent < 1700) begin
      pick_idling(ph);
      set_phase(wmmf_pkg::mode_t'($urandom_range(1)), $urandom_range(1, 8),
                $urandom_range(1, 6));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(5) == 0) begin
          // mode change only with the pipe empty
          wait_drain();
          write_cfg(wmmf_pkg::CFG_MODE, $urandom_range(1));
          cfg_valid <= 1'b0;
        end
        run_frame(3);
      end
      if ($urandom_range(5) == 0)
        repeat ($urandom_range(1, 30)) send_word(pick_word($urandom_range(1)));
      ph++;
    end
    wait_drain();

    $display("covered %0d words, %0d frames, %0d results in mean and median modes",
             words_sent, frames_done, sb.results);
    $display("sizes from 1x1 to saturated extremes, with sender idling and result stalls");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_window_3x3_mean_median_filter passed");
    end else begin
      $display("tb_window_3x3_mean_median_filter failed");
    end
    $finish;
  end

  initial begin
    #80000000;
    $display("tb_window_3x3_mean_median_filter failed");
    $finish;
  end
endmodule
